/* rtl/core/mbcrc_pkg.sv */
// Shared types, constants and the byte-wide CRC-16 update for the Modbus
// response deframer. No dependencies.
`timescale 1ns / 1ps

package mbcrc_pkg;

  localparam int unsigned ValueCountDefault = 3;
  localparam int unsigned StoreDepth        = 3;
  localparam int unsigned SlotW             = $clog2(StoreDepth);
  localparam int unsigned CountW            = 5;
  localparam logic [CountW-1:0] CountMax    = '1;
  localparam int unsigned HeaderLen         = 3;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusBadLen = 2'd1;
  localparam logic [1:0] StatusBadCrc = 2'd2;

  typedef enum logic [2:0] {
    OP_IGNORE    = 3'd0,
    OP_CRC       = 3'd1,
    OP_CRC_STORE = 3'd2,
    OP_CRC_LO    = 3'd3,
    OP_CRC_HI    = 3'd4
  } mbcrc_op_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } mbcrc_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value_first;
    logic signed [31:0] value_second;
    logic signed [31:0] value_third;
    logic [15:0]        crc_received;
    logic [15:0]        crc_computed;
  } mbcrc_out_t;

  // One classified byte as it travels from the front to the back.
  typedef struct packed {
    mbcrc_op_e        op;
    logic [SlotW-1:0] slot;
    logic [7:0]       data;
    logic             last;
    logic             len_ok;
  } mbcrc_cmd_t;

  // Reflected CRC-16 update over one byte, LSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/core/mbcrc_front.sv */
// Front end: counts byte positions within a frame and tags each byte with
// what the back end must do with it. Depends on mbcrc_pkg.
`timescale 1ns / 1ps

module mbcrc_front import mbcrc_pkg::*; #(
  parameter int unsigned VALUE_COUNT = ValueCountDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  mbcrc_in_t  in_i,
  output mbcrc_cmd_t cmd_o
);

  localparam logic [5:0] PayloadLen = 6'(HeaderLen + 4 * VALUE_COUNT);
  localparam logic [5:0] LastPos    = 6'(HeaderLen + 4 * VALUE_COUNT + 1);

  logic [CountW-1:0] cnt_q, cnt_d;
  logic [5:0]        pos;
  logic [5:0]        slot_full;

  assign pos       = {1'b0, cnt_q};
  assign slot_full = (pos - 6'(HeaderLen)) >> 2;

  always_comb begin
    cmd_o.op     = OP_IGNORE;
    cmd_o.slot   = slot_full[SlotW-1:0];
    cmd_o.data   = in_i.rx_byte;
    cmd_o.last   = in_i.frame_end;
    cmd_o.len_ok = (pos == LastPos);
    if (cnt_q != CountMax) begin
      if (pos < PayloadLen) begin
        if (pos >= 6'(HeaderLen) && slot_full < 6'(StoreDepth)) begin
          cmd_o.op = OP_CRC_STORE;
        end else begin
          cmd_o.op = OP_CRC;
        end
      end else if (pos == PayloadLen) begin
        cmd_o.op = OP_CRC_LO;
      end else if (pos == PayloadLen + 6'd1) begin
        cmd_o.op = OP_CRC_HI;
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (accept_i) begin
      if (in_i.frame_end) begin
        cnt_d = '0;
      end else if (cnt_q != CountMax) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/core/mbcrc_queue.sv */
// Short command queue between the front and back ends, so that each side
// can stall on its own. Depends on mbcrc_pkg.
`timescale 1ns / 1ps

module mbcrc_queue import mbcrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_i,
  input  mbcrc_cmd_t wr_data_i,
  output logic       full_o,
  input  logic       rd_i,
  output logic       valid_o,
  output mbcrc_cmd_t rd_data_o
);

  mbcrc_cmd_t           mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;

  assign full_o    = (cnt_q == QueueCntW'(QueueDepth));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  function automatic logic [QueuePtrW-1:0] ptr_inc(input logic [QueuePtrW-1:0] p);
    return (p == QueuePtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (rd_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/mbcrc_back.sv */
// Back end: runs the CRC, assembles the values and the received CRC, and
// builds the frame result in an output register. Depends on mbcrc_pkg.
`timescale 1ns / 1ps

module mbcrc_back import mbcrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       cmd_valid_i,
  input  mbcrc_cmd_t cmd_i,
  output logic       cmd_take_o,
  output logic       res_valid_o,
  input  logic       res_pop_i,
  output mbcrc_out_t res_o
);

  logic [7:0]  offset_q;
  logic [15:0] crc_q, crc_d;
  logic [15:0] rcrc_q, rcrc_d;
  logic [31:0] val_q [StoreDepth];
  logic [31:0] val_d [StoreDepth];
  logic        res_valid_q;
  mbcrc_out_t  res_q;
  logic        res_free;
  logic        done;

  // The result register may be refilled in the same cycle its beat is taken.
  assign res_free    = !res_valid_q || res_pop_i;
  assign cmd_take_o  = cmd_valid_i && (!cmd_i.last || res_free);
  assign done        = cmd_take_o && cmd_i.last;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    crc_d  = crc_q;
    rcrc_d = rcrc_q;
    for (int k = 0; k < StoreDepth; k++) begin
      val_d[k] = val_q[k];
    end
    unique case (cmd_i.op)
      OP_CRC: begin
        crc_d = crc16_byte(crc_q, cmd_i.data);
      end
      OP_CRC_STORE: begin
        crc_d = crc16_byte(crc_q, cmd_i.data);
        for (int k = 0; k < StoreDepth; k++) begin
          if (cmd_i.slot == SlotW'(k)) begin
            val_d[k] = {val_q[k][23:0], cmd_i.data};
          end
        end
      end
      OP_CRC_LO: rcrc_d = {rcrc_q[15:8], cmd_i.data};
      OP_CRC_HI: rcrc_d = {cmd_i.data, rcrc_q[7:0]};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (cfg_we_i) begin
      offset_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CrcInit;
      rcrc_q <= '0;
      for (int k = 0; k < StoreDepth; k++) begin
        val_q[k] <= '0;
      end
    end else if (cmd_take_o) begin
      if (cmd_i.last) begin
        crc_q  <= CrcInit;
        rcrc_q <= '0;
        for (int k = 0; k < StoreDepth; k++) begin
          val_q[k] <= '0;
        end
      end else begin
        crc_q  <= crc_d;
        rcrc_q <= rcrc_d;
        for (int k = 0; k < StoreDepth; k++) begin
          val_q[k] <= val_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (done) begin
      res_valid_q <= 1'b1;
    end else if (res_pop_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      if (!cmd_i.len_ok) begin
        res_q.status <= StatusBadLen;
      end else if (rcrc_d != crc_d) begin
        res_q.status <= StatusBadCrc;
      end else begin
        res_q.status <= StatusOk;
      end
      res_q.value_first  <= $signed(val_d[0] - {24'd0, offset_q});
      res_q.value_second <= $signed(val_d[1] - {24'd0, offset_q});
      res_q.value_third  <= $signed(val_d[2] - {24'd0, offset_q});
      res_q.crc_received <= rcrc_d;
      res_q.crc_computed <= crc_d;
    end
  end

endmodule

/* rtl/core/modbus_response_crc_deframer.sv */
// Top level of the Modbus RTU response deframer with CRC-16 check.
// Depends on mbcrc_pkg, mbcrc_front, mbcrc_queue and mbcrc_back.
`timescale 1ns / 1ps

// Feed the response one byte per beat with frame_end set on the last byte;
// one result beat follows each frame: status (ok, wrong length, CRC
// mismatch), the three values minus value_offset, and both CRCs. A byte is
// taken every cycle while full is low. Once the last byte is accepted and
// nothing waits ahead of it, the result passes through a two-entry queue
// and then the output register; full rises only when a finished result
// has not been popped and a further frame end stands at the head of that
// queue with one more byte behind it. The user must write value_offset only
// between frames; the block itself does not enforce this.
module modbus_response_crc_deframer import mbcrc_pkg::*; #(
  parameter int unsigned VALUE_COUNT = ValueCountDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       push,
  output logic       full,
  input  mbcrc_in_t  in_i,
  output logic       empty,
  input  logic       pop,
  output mbcrc_out_t out_o
);

  logic       accept;
  mbcrc_cmd_t front_cmd;
  mbcrc_cmd_t back_cmd;
  logic       q_full;
  logic       q_valid;
  logic       q_take;
  logic       res_valid;

  assign accept = push && !q_full;
  assign full   = q_full;
  assign empty  = !res_valid;

  mbcrc_front #(
    .VALUE_COUNT(VALUE_COUNT)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .in_i    (in_i),
    .cmd_o   (front_cmd)
  );

  mbcrc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (accept),
    .wr_data_i(front_cmd),
    .full_o   (q_full),
    .rd_i     (q_take),
    .valid_o  (q_valid),
    .rd_data_o(back_cmd)
  );

  mbcrc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_valid_i(q_valid),
    .cmd_i      (back_cmd),
    .cmd_take_o (q_take),
    .res_valid_o(res_valid),
    .res_pop_i  (pop && res_valid),
    .res_o      (out_o)
  );

endmodule
